/* hw/rtl/adn_pkg.sv */
// ----------------------------------------------------------------------------
// adn_pkg
// Shared types and constants of the Art-Net ArtDMX receiver core.
// ----------------------------------------------------------------------------
`default_nettype none

package adn_pkg;

  // Operation field codes
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // Art-Net opcodes (little-endian on the wire)
  localparam logic [15:0] OpPoll = 16'h2000;
  localparam logic [15:0] OpDmx  = 16'h5000;

  // Byte position counter
  localparam int unsigned PosW = 10;
  localparam logic [PosW-1:0] PosMax = 10'd1023;

  // Header byte offsets
  localparam logic [PosW-1:0] PosOpLo  = 10'd8;
  localparam logic [PosW-1:0] PosOpHi  = 10'd9;
  localparam logic [PosW-1:0] PosUniLo = 10'd14;
  localparam logic [PosW-1:0] PosUniHi = 10'd15;
  localparam logic [PosW-1:0] PosLenHi = 10'd16;
  localparam logic [PosW-1:0] PosLenLo = 10'd17;
  localparam logic [PosW-1:0] DataStart = 10'd18;

  // Frame counter slots, fixed by the fps outputs
  localparam int unsigned CounterSlots = 4;
  localparam int unsigned UniW = 2;
  localparam int unsigned SlotW = 9;

  typedef logic [CounterSlots-1:0][7:0] fps_arr_t;

  // Input request
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } dmx_in_t;

  // Result
  typedef struct packed {
    logic             write_valid;
    logic [UniW-1:0]  write_universe;
    logic [SlotW-1:0] write_slot;
    logic [7:0]       write_value;
    logic             poll_reply_request;
    logic             frame_received;
    logic [7:0]       fps_u0;
    logic [7:0]       fps_u1;
    logic [7:0]       fps_u2;
    logic [7:0]       fps_u3;
  } dmx_out_t;

  // Per-byte events from the header parser
  typedef struct packed {
    logic             wr_valid;
    logic [UniW-1:0]  wr_universe;
    logic [SlotW-1:0] wr_slot;
    logic [7:0]       wr_value;
    logic             poll;
    logic             frame;
    logic [UniW-1:0]  frame_uni;
  } hdr_evt_t;

endpackage

`default_nettype wire

/* hw/rtl/adn_hdr.sv */
// ----------------------------------------------------------------------------
// adn_hdr
// Packet header parser: tracks the byte position, assembles opcode,
// universe and length, and decides buffer writes, poll and frame events.
// ----------------------------------------------------------------------------
`default_nettype none

module adn_hdr #(
  parameter int unsigned NUM_UNIVERSES      = 4,
  parameter int unsigned SLOTS_PER_UNIVERSE = 512
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             byte_acc_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  output adn_pkg::hdr_evt_t     evt_o
);

  localparam int unsigned UniLimit =
      (NUM_UNIVERSES < adn_pkg::CounterSlots) ? NUM_UNIVERSES : adn_pkg::CounterSlots;

  logic [adn_pkg::PosW-1:0] pos_q, pos_d;
  logic [15:0] opcode_q, opcode_d;
  logic [15:0] universe_q, universe_d;
  logic [15:0] length_q, length_d;

  logic                     uni_ok;
  logic                     is_dmx;
  logic [adn_pkg::PosW-1:0] slot;
  logic                     wr;

  // Header field capture, including the byte now arriving
  always_comb begin
    opcode_d   = opcode_q;
    universe_d = universe_q;
    length_d   = length_q;
    case (pos_q)
      adn_pkg::PosOpLo:  opcode_d[7:0]    = data_byte_i;
      adn_pkg::PosOpHi:  opcode_d[15:8]   = data_byte_i;
      adn_pkg::PosUniLo: universe_d[7:0]  = data_byte_i;
      adn_pkg::PosUniHi: universe_d[15:8] = data_byte_i;
      adn_pkg::PosLenHi: length_d[15:8]   = data_byte_i;
      adn_pkg::PosLenLo: length_d[7:0]    = data_byte_i;
      default: ;
    endcase
  end

  // Write and end-of-packet decisions
  always_comb begin
    uni_ok = (universe_d < 16'(UniLimit));
    is_dmx = (opcode_d == adn_pkg::OpDmx) && uni_ok;
    slot   = pos_q - adn_pkg::DataStart;
    wr     = (pos_q >= adn_pkg::DataStart) && is_dmx &&
             ({6'd0, slot} < length_d) &&
             (slot < adn_pkg::PosW'(SLOTS_PER_UNIVERSE));

    evt_o             = '0;
    evt_o.wr_valid    = wr;
    evt_o.wr_universe = wr ? universe_d[adn_pkg::UniW-1:0] : '0;
    evt_o.wr_slot     = wr ? slot[adn_pkg::SlotW-1:0] : '0;
    evt_o.wr_value    = wr ? data_byte_i : '0;
    evt_o.poll        = last_byte_i && (pos_q >= adn_pkg::PosOpHi) &&
                        (opcode_d == adn_pkg::OpPoll);
    evt_o.frame       = last_byte_i && (pos_q >= adn_pkg::PosLenLo) && is_dmx;
    // counter slot of the frame, valid whether or not this byte is written
    evt_o.frame_uni   = universe_d[adn_pkg::UniW-1:0];
  end

  // Next position: restart after the last byte, saturate on long packets
  always_comb begin
    if (last_byte_i) begin
      pos_d = '0;
    end else if (pos_q < adn_pkg::PosMax) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      opcode_q   <= '0;
      universe_q <= '0;
      length_q   <= '0;
    end else if (byte_acc_i) begin
      pos_q <= pos_d;
      if (last_byte_i) begin
        opcode_q   <= '0;
        universe_q <= '0;
        length_q   <= '0;
      end else begin
        opcode_q   <= opcode_d;
        universe_q <= universe_d;
        length_q   <= length_d;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/adn_fps.sv */
// ----------------------------------------------------------------------------
// adn_fps
// Frame counters per universe; a tick latches them as rates and clears them.
// ----------------------------------------------------------------------------
`default_nettype none

module adn_fps (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        tick_i,
  input  wire logic                        frame_i,
  input  wire logic [adn_pkg::UniW-1:0]    frame_uni_i,
  output adn_pkg::fps_arr_t                rate_o
);

  adn_pkg::fps_arr_t cnt_q, cnt_d;
  adn_pkg::fps_arr_t rate_q, rate_d;

  // Count, or latch and clear on a tick
  always_comb begin
    cnt_d  = cnt_q;
    rate_d = rate_q;
    if (tick_i) begin
      rate_d = cnt_q;
      cnt_d  = '0;
    end else if (frame_i) begin
      cnt_d[frame_uni_i] = cnt_q[frame_uni_i] + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rate_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      rate_q <= rate_d;
    end
  end

  // Rates as they stand after this request
  assign rate_o = rate_d;

endmodule

`default_nettype wire

/* hw/rtl/adn_outreg.sv */
// ----------------------------------------------------------------------------
// adn_outreg
// Result register with valid/ready; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module adn_outreg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  adn_pkg::dmx_out_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output adn_pkg::dmx_out_t  out_data_o
);

  logic              valid_q;
  adn_pkg::dmx_out_t data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/artnet_dmx_receiver_core.sv */
// ----------------------------------------------------------------------------
// artnet_dmx_receiver_core
// Art-Net receiver: parses ArtDMX/ArtPoll from UDP payload bytes, emits DMX
// buffer writes, poll reply requests and per-universe frame rates.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+----------------------
//   in      | input     | in_valid_i/in_ready_o  | in_data_i  (dmx_in_t)
//   out     | output    | out_valid_o/out_ready_i| out_data_o (dmx_out_t)
//
// One request per clock while in_ready_o is high; each request yields one result,
// held in the result register and presented in the cycle after it is accepted.
// Header parse, write decision and counters settle in the accept cycle.
// A stalled output blocks input only while the result register is full
// and not being drained.
// Reset clears the header state, counters, rates and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module artnet_dmx_receiver_core #(
  parameter int unsigned NUM_UNIVERSES      = 4,
  parameter int unsigned SLOTS_PER_UNIVERSE = 512
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  adn_pkg::dmx_in_t   in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output adn_pkg::dmx_out_t  out_data_o
);

  logic              accept;
  logic              byte_acc;
  logic              tick_acc;
  adn_pkg::hdr_evt_t evt;
  adn_pkg::fps_arr_t rate;
  adn_pkg::dmx_out_t res;

  assign accept   = in_valid_i && in_ready_o;
  assign byte_acc = accept && (in_data_i.operation == adn_pkg::OpByte);
  assign tick_acc = accept && (in_data_i.operation == adn_pkg::OpTick);

  adn_hdr #(
    .NUM_UNIVERSES      (NUM_UNIVERSES),
    .SLOTS_PER_UNIVERSE (SLOTS_PER_UNIVERSE)
  ) u_hdr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_acc_i  (byte_acc),
    .data_byte_i (in_data_i.data_byte),
    .last_byte_i (in_data_i.last_byte),
    .evt_o       (evt)
  );

  adn_fps u_fps (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_acc),
    .frame_i     (byte_acc && evt.frame),
    .frame_uni_i (evt.frame_uni),
    .rate_o      (rate)
  );

  // Result assembly; byte events are dropped on a tick
  always_comb begin
    res = '0;
    if (in_data_i.operation == adn_pkg::OpByte) begin
      res.write_valid        = evt.wr_valid;
      res.write_universe     = evt.wr_universe;
      res.write_slot         = evt.wr_slot;
      res.write_value        = evt.wr_value;
      res.poll_reply_request = evt.poll;
      res.frame_received     = evt.frame;
    end
    res.fps_u0 = rate[0];
    res.fps_u1 = rate[1];
    res.fps_u2 = rate[2];
    res.fps_u3 = rate[3];
  end

  adn_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
